/* src/slhb_pkg.sv */
// Shared types, constants and the status-code decoder for the status LED
// heartbeat / blink-code core. No dependencies.
package slhb_pkg;

    localparam int TimeW   = 32;
    localparam int MsW     = 16;
    localparam int StatusW = 3;
    localparam int CfgIdxW = 2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_HB_SHORT  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HB_LONG   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_BLINK_STEP = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_BLINK_GAP = 2'd3;

    // configuration reset values
    localparam logic [MsW-1:0] HB_SHORT_RST   = 16'd100;
    localparam logic [MsW-1:0] HB_LONG_RST    = 16'd700;
    localparam logic [MsW-1:0] BLINK_STEP_RST = 16'd100;
    localparam logic [MsW-1:0] BLINK_GAP_RST  = 16'd1000;

    // motor status codes
    localparam logic [StatusW-1:0] ST_NO_CALIB = 3'd0;
    localparam logic [StatusW-1:0] ST_RUNNING  = 3'd1;
    localparam logic [StatusW-1:0] ST_FINISH   = 3'd2;
    localparam logic [StatusW-1:0] ST_STOP     = 3'd3;
    localparam logic [StatusW-1:0] ST_OVERLOAD = 3'd4;
    localparam logic [StatusW-1:0] ST_STALL    = 3'd5;

    // heartbeat phases
    localparam logic [1:0] HB_PH1 = 2'd0;
    localparam logic [1:0] HB_PH2 = 2'd1;
    localparam logic [1:0] HB_PH3 = 2'd2;
    localparam logic [1:0] HB_PH4 = 2'd3;

    // blink-code phases
    localparam logic [1:0] BL_ON  = 2'd0;
    localparam logic [1:0] BL_OFF = 2'd1;
    localparam logic [1:0] BL_GAP = 2'd2;

    typedef struct packed {
        logic       lamp;
        logic       beat;
        logic [1:0] target;
    } t_flags;

    function automatic t_flags decode_status(input logic [StatusW-1:0] status,
                                             input t_flags cur);
        t_flags f;
        f = cur;
        unique case (status)
            ST_NO_CALIB: f = '{lamp: 1'b0, beat: 1'b0, target: 2'd1};
            ST_RUNNING:  f = '{lamp: 1'b1, beat: 1'b1, target: 2'd0};
            ST_FINISH:   f = '{lamp: 1'b1, beat: 1'b0, target: 2'd0};
            ST_STOP:     f = '{lamp: 1'b0, beat: 1'b0, target: 2'd0};
            ST_OVERLOAD: f = '{lamp: 1'b1, beat: 1'b0, target: 2'd3};
            ST_STALL:    f = '{lamp: 1'b0, beat: 1'b0, target: 2'd2};
            default:     f = cur;
        endcase
        return f;
    endfunction

endpackage

/* src/slhb_beat.sv */
// Heartbeat phase machine for the status LED.
// Depends on slhb_pkg.
module slhb_beat (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [slhb_pkg::MsW-1:0]   i_elapsed_ms,
    input  slhb_pkg::t_flags           i_flags,
    input  logic [slhb_pkg::MsW-1:0]   i_short_ms,
    input  logic [slhb_pkg::MsW-1:0]   i_long_ms,
    output logic                       o_level_next
);

    // time since the last transition, tracked directly instead of a mark
    logic [slhb_pkg::TimeW-1:0] r_since, n_since;
    logic [1:0]                 r_phase, n_phase;
    logic                       r_level, n_level;
    logic [slhb_pkg::TimeW-1:0] since_sum;
    logic [slhb_pkg::MsW-1:0]   limit;
    logic                       hit;

    always_comb begin
        since_sum = r_since + {{(slhb_pkg::TimeW-slhb_pkg::MsW){1'b0}}, i_elapsed_ms};
        limit     = (r_phase == slhb_pkg::HB_PH4) ? i_long_ms : i_short_ms;
        hit       = since_sum > {{(slhb_pkg::TimeW-slhb_pkg::MsW){1'b0}}, limit};
        n_since   = since_sum;
        n_phase   = r_phase;
        n_level   = r_level;
        if (!i_flags.lamp) begin
            n_level = 1'b0;
        end else if (!i_flags.beat) begin
            n_level = 1'b1;
            n_phase = slhb_pkg::HB_PH1;
        end else if (hit) begin
            // phases one and three end dark, two and four end lit
            n_level = r_phase[0];
            n_phase = r_phase + 2'd1;
            n_since = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= '0;
            r_phase <= slhb_pkg::HB_PH1;
            r_level <= 1'b0;
        end else if (i_step) begin
            r_since <= n_since;
            r_phase <= n_phase;
            r_level <= n_level;
        end
    end

    assign o_level_next = n_level;

endmodule

/* src/slhb_blink.sv */
// Blink-code phase machine for the error LED.
// Depends on slhb_pkg.
module slhb_blink (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [slhb_pkg::MsW-1:0]   i_elapsed_ms,
    input  slhb_pkg::t_flags           i_flags,
    input  logic [slhb_pkg::MsW-1:0]   i_step_ms,
    input  logic [slhb_pkg::MsW-1:0]   i_gap_ms,
    output logic                       o_level_next
);

    logic [slhb_pkg::TimeW-1:0] r_since, n_since;
    logic [1:0]                 r_phase, n_phase;
    logic [2:0]                 r_count, n_count;
    logic                       r_level, n_level;
    logic [slhb_pkg::TimeW-1:0] since_sum;
    logic [slhb_pkg::MsW-1:0]   limit;
    logic                       hit;
    logic [2:0]                 count_inc;

    always_comb begin
        since_sum = r_since + {{(slhb_pkg::TimeW-slhb_pkg::MsW){1'b0}}, i_elapsed_ms};
        limit     = (r_phase == slhb_pkg::BL_GAP) ? i_gap_ms : i_step_ms;
        hit       = since_sum > {{(slhb_pkg::TimeW-slhb_pkg::MsW){1'b0}}, limit};
        count_inc = r_count + 3'd1;
        n_since   = since_sum;
        n_phase   = r_phase;
        n_count   = r_count;
        n_level   = r_level;
        case (r_phase)
            slhb_pkg::BL_ON: begin
                if (hit) begin
                    n_level = 1'b0;
                    n_phase = slhb_pkg::BL_OFF;
                    n_since = '0;
                end
            end
            slhb_pkg::BL_OFF: begin
                if (hit) begin
                    n_count = count_inc;
                    n_since = '0;
                    if ({1'b0, i_flags.target} > count_inc) begin
                        n_level = 1'b1;
                        n_phase = slhb_pkg::BL_ON;
                    end else begin
                        n_level = 1'b0;
                        n_phase = slhb_pkg::BL_GAP;
                    end
                end
            end
            slhb_pkg::BL_GAP: begin
                if (hit) begin
                    n_count = '0;
                    n_level = (i_flags.target != 2'd0);
                    n_phase = slhb_pkg::BL_ON;
                    n_since = '0;
                end
            end
            default: begin
                // unused code: return to the first phase, keep the mark
                n_phase = slhb_pkg::BL_ON;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= '0;
            r_phase <= slhb_pkg::BL_ON;
            r_count <= '0;
            r_level <= 1'b0;
        end else if (i_step) begin
            r_since <= n_since;
            r_phase <= n_phase;
            r_count <= n_count;
            r_level <= n_level;
        end
    end

    assign o_level_next = n_level;

endmodule

/* src/status_led_heartbeat_blink_code_core.sv */
// Top level of the status LED heartbeat / error LED blink-code core.
// Depends on slhb_pkg, slhb_beat and slhb_blink.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one tick word: the
//   milliseconds since the previous tick and the motor status code.
//   Output channel (o_out_valid / i_out_ready) returns one word per tick:
//   the held status LED level and error LED level.
//   Configuration: write i_cfg_data to register i_cfg_index while
//   i_cfg_we is high; 0 heartbeat short, 1 heartbeat long, 2 blink step,
//   3 blink gap (all in ms). Write only while no tick is in flight.
//   A tick is held in the input register, then evaluated, and its result
//   is registered in the output register. Throughput: one tick per clock
//   unless stalled, with one 32-bit add and compare per LED machine.
//   Reset (synchronous, active low) clears both valid flags, all timers,
//   the phase machines with their LED levels and the status flags, and
//   loads the default thresholds.
//   When the receiver stalls, the result is held in the output register
//   and one more tick is held in the input register; o_in_ready drops
//   only when both are full.
module status_led_heartbeat_blink_code_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [slhb_pkg::MsW-1:0]         i_elapsed_ms,
    input  logic [slhb_pkg::StatusW-1:0]     i_motor_status,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_status_led_on,
    output logic                             o_error_led_on,
    input  logic                             i_cfg_we,
    input  logic [slhb_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [slhb_pkg::MsW-1:0]         i_cfg_data
);

    logic [slhb_pkg::MsW-1:0]     r_hb_short, r_hb_long, r_bl_step, r_bl_gap;
    logic                         r_in_valid;
    logic [slhb_pkg::MsW-1:0]     r_elapsed;
    logic [slhb_pkg::StatusW-1:0] r_status;
    slhb_pkg::t_flags             r_flags, n_flags;
    logic                         r_out_valid;
    logic                         r_status_led, r_error_led;
    logic                         out_free;
    logic                         step;
    logic                         status_next, error_next;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign n_flags    = slhb_pkg::decode_status(r_status, r_flags);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb_short <= slhb_pkg::HB_SHORT_RST;
            r_hb_long  <= slhb_pkg::HB_LONG_RST;
            r_bl_step  <= slhb_pkg::BLINK_STEP_RST;
            r_bl_gap   <= slhb_pkg::BLINK_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                slhb_pkg::CFG_HB_SHORT:   r_hb_short <= i_cfg_data;
                slhb_pkg::CFG_HB_LONG:    r_hb_long  <= i_cfg_data;
                slhb_pkg::CFG_BLINK_STEP: r_bl_step  <= i_cfg_data;
                slhb_pkg::CFG_BLINK_GAP:  r_bl_gap   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_elapsed <= i_elapsed_ms;
            r_status  <= i_motor_status;
        end
    end

    // status flags advance with each evaluated tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (step) begin
            r_flags <= n_flags;
        end
    end

    slhb_beat u_beat (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_elapsed_ms (r_elapsed),
        .i_flags      (n_flags),
        .i_short_ms   (r_hb_short),
        .i_long_ms    (r_hb_long),
        .o_level_next (status_next)
    );

    slhb_blink u_blink (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_elapsed_ms (r_elapsed),
        .i_flags      (n_flags),
        .i_step_ms    (r_bl_step),
        .i_gap_ms     (r_bl_gap),
        .o_level_next (error_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_status_led <= status_next;
            r_error_led  <= error_next;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status_led_on = r_status_led;
    assign o_error_led_on  = r_error_led;

endmodule

/* src/slhb_checker.sv */
// Port-level checks for the status LED heartbeat / blink-code core,
// bound to the top level. Depends on slhb_pkg for widths.
module slhb_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_ready,
    input  logic [slhb_pkg::MsW-1:0]         i_elapsed_ms,
    input  logic [slhb_pkg::StatusW-1:0]     i_motor_status,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic                             o_status_led_on,
    input  logic                             o_error_led_on,
    input  logic                             i_cfg_we,
    input  logic [slhb_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [slhb_pkg::MsW-1:0]         i_cfg_data
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

    // the input side only stalls when a result word is blocked
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while output was free");

    // an accepted tick passes the input and result registers into a valid result word
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##2 o_out_valid)
        else $error("accepted tick produced no result");

    // a stalled result word holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_status_led_on) && $stable(o_error_led_on)))
        else $error("stalled result word changed");

endmodule

bind status_led_heartbeat_blink_code_core slhb_checker u_slhb_checker (.*);

/* tb/status_led_heartbeat_blink_code_core_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for status_led_heartbeat_blink_code_core: a directed table, then random
// tick sequences under several threshold settings, checked against an in-bench LED predictor.
// Depends on slhb_pkg and the core RTL.
module status_led_heartbeat_blink_code_core_test;

    localparam int IdleLimit   = 4000;
    localparam int DrainCycles = 4;
    localparam int ScriptLen   = 21;
    localparam int PhaseTicks  = 60;

    typedef struct packed {
        logic status_on;
        logic error_on;
    } t_led_pair;

    typedef struct packed {
        logic [slhb_pkg::MsW-1:0]     ms;
        logic [slhb_pkg::StatusW-1:0] code;
        logic                         typed;
        t_led_pair                    leds;
    } t_tick_row;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_in_valid     = 1'b0;
    logic                         o_in_ready;
    logic [slhb_pkg::MsW-1:0]     i_elapsed_ms   = '0;
    logic [slhb_pkg::StatusW-1:0] i_motor_status = slhb_pkg::ST_STOP;
    logic                         o_out_valid;
    logic                         i_out_ready    = 1'b0;
    logic                         o_status_led_on;
    logic                         o_error_led_on;
    logic                         i_cfg_we       = 1'b0;
    logic [slhb_pkg::CfgIdxW-1:0] i_cfg_index    = slhb_pkg::CFG_HB_SHORT;
    logic [slhb_pkg::MsW-1:0]     i_cfg_data     = '0;

    status_led_heartbeat_blink_code_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_elapsed_ms    (i_elapsed_ms),
        .i_motor_status  (i_motor_status),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status_led_on (o_status_led_on),
        .o_error_led_on  (o_error_led_on),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state, starts at its reset values
    logic [slhb_pkg::MsW-1:0]   thr_short = slhb_pkg::HB_SHORT_RST;
    logic [slhb_pkg::MsW-1:0]   thr_long  = slhb_pkg::HB_LONG_RST;
    logic [slhb_pkg::MsW-1:0]   thr_step  = slhb_pkg::BLINK_STEP_RST;
    logic [slhb_pkg::MsW-1:0]   thr_gap   = slhb_pkg::BLINK_GAP_RST;
    logic [slhb_pkg::TimeW-1:0] ms_clock  = '0;
    logic [slhb_pkg::TimeW-1:0] beat_mark = '0;
    logic [slhb_pkg::TimeW-1:0] code_mark = '0;
    logic             lamp_on   = 1'b0;
    logic             beat_on   = 1'b0;
    logic [1:0]       pulse_goal = 2'd0;
    logic [2:0]       pulses    = 3'd0;
    logic [1:0]       beat_ph   = slhb_pkg::HB_PH1;
    logic [1:0]       code_ph   = slhb_pkg::BL_ON;
    logic             beat_lvl  = 1'b0;
    logic             code_lvl  = 1'b0;

    t_led_pair led_levels_q[$];
    int        failures    = 0;
    int        idle_cycles = 0;
    logic      word_taken  = 1'b0;
    logic      tick_typed  = 1'b0;
    t_led_pair tick_leds   = '0;

    // sender and receiver pacing
    int        burst_left  = 0;
    bit        gaps_on     = 1'b1;
    logic [1:0] stall_style = 2'd0;
    logic [7:0] ready_pattern = '1;
    logic [2:0] stall_slot  = '0;

    // directed ticks, run with the reset thresholds; leds are {status, error}
    t_tick_row script [ScriptLen] = '{
        '{16'd0,     slhb_pkg::ST_STOP,     1'b1, 2'b00},
        '{16'd65535, slhb_pkg::ST_FINISH,   1'b1, 2'b10},
        '{16'd101,   slhb_pkg::ST_OVERLOAD, 1'b1, 2'b11},
        '{16'd100,   3'd6,                  1'b0, 2'b00},
        '{16'd1,     3'd7,                  1'b0, 2'b00},
        '{16'd200,   slhb_pkg::ST_OVERLOAD, 1'b0, 2'b00},
        '{16'd200,   slhb_pkg::ST_OVERLOAD, 1'b0, 2'b00},
        '{16'd200,   slhb_pkg::ST_OVERLOAD, 1'b0, 2'b00},
        '{16'd1001,  slhb_pkg::ST_RUNNING,  1'b0, 2'b00},
        '{16'd101,   slhb_pkg::ST_RUNNING,  1'b0, 2'b00},
        '{16'd101,   slhb_pkg::ST_RUNNING,  1'b0, 2'b00},
        '{16'd700,   slhb_pkg::ST_RUNNING,  1'b0, 2'b00},
        '{16'd1,     slhb_pkg::ST_RUNNING,  1'b0, 2'b00},
        '{16'd0,     slhb_pkg::ST_STALL,    1'b0, 2'b00},
        '{16'd1000,  slhb_pkg::ST_NO_CALIB, 1'b0, 2'b00},
        '{16'd150,   slhb_pkg::ST_NO_CALIB, 1'b0, 2'b00},
        '{16'd150,   slhb_pkg::ST_STALL,    1'b0, 2'b00},
        '{16'd150,   slhb_pkg::ST_STALL,    1'b0, 2'b00},
        '{16'd1500,  slhb_pkg::ST_STOP,     1'b0, 2'b00},
        '{16'd65535, 3'd6,                  1'b0, 2'b00},
        '{16'd0,     3'd7,                  1'b0, 2'b00}
    };

    function automatic t_led_pair next_led_levels(input logic [slhb_pkg::MsW-1:0] ms,
                                                  input logic [slhb_pkg::StatusW-1:0] code);
        logic [slhb_pkg::TimeW-1:0] since;
        logic [slhb_pkg::TimeW-1:0] limit;
        ms_clock = ms_clock + slhb_pkg::TimeW'(ms);

        case (code)
            slhb_pkg::ST_NO_CALIB: begin
                lamp_on = 1'b0; beat_on = 1'b0; pulse_goal = 2'd1;
            end
            slhb_pkg::ST_RUNNING: begin
                lamp_on = 1'b1; beat_on = 1'b1; pulse_goal = 2'd0;
            end
            slhb_pkg::ST_FINISH: begin
                lamp_on = 1'b1; beat_on = 1'b0; pulse_goal = 2'd0;
            end
            slhb_pkg::ST_STOP: begin
                lamp_on = 1'b0; beat_on = 1'b0; pulse_goal = 2'd0;
            end
            slhb_pkg::ST_OVERLOAD: begin
                lamp_on = 1'b1; beat_on = 1'b0; pulse_goal = 2'd3;
            end
            slhb_pkg::ST_STALL: begin
                lamp_on = 1'b0; beat_on = 1'b0; pulse_goal = 2'd2;
            end
            default: ;  // keep the flags
        endcase

        if (!lamp_on) begin
            beat_lvl = 1'b0;
        end else if (!beat_on) begin
            beat_lvl = 1'b1;
            beat_ph  = slhb_pkg::HB_PH1;
        end else begin
            limit = (beat_ph == slhb_pkg::HB_PH4) ? slhb_pkg::TimeW'(thr_long)
                                                  : slhb_pkg::TimeW'(thr_short);
            since = ms_clock - beat_mark;
            if (since > limit) begin
                // phases one and three end dark, two and four end lit
                beat_lvl  = beat_ph[0];
                beat_mark = ms_clock;
                beat_ph   = beat_ph + 2'd1;
            end
        end

        since = ms_clock - code_mark;
        case (code_ph)
            slhb_pkg::BL_ON: begin
                if (since > slhb_pkg::TimeW'(thr_step)) begin
                    code_lvl  = 1'b0;
                    code_mark = ms_clock;
                    code_ph   = slhb_pkg::BL_OFF;
                end
            end
            slhb_pkg::BL_OFF: begin
                if (since > slhb_pkg::TimeW'(thr_step)) begin
                    pulses = pulses + 3'd1;
                    if ({1'b0, pulse_goal} > pulses) begin
                        code_lvl = 1'b1;
                        code_ph  = slhb_pkg::BL_ON;
                    end else begin
                        code_lvl = 1'b0;
                        code_ph  = slhb_pkg::BL_GAP;
                    end
                    code_mark = ms_clock;
                end
            end
            slhb_pkg::BL_GAP: begin
                if (since > slhb_pkg::TimeW'(thr_gap)) begin
                    pulses    = 3'd0;
                    code_lvl  = (pulse_goal != 2'd0);
                    code_mark = ms_clock;
                    code_ph   = slhb_pkg::BL_ON;
                end
            end
            default: code_ph = slhb_pkg::BL_ON;
        endcase

        return '{status_on: beat_lvl, error_on: code_lvl};
    endfunction

    // check results, record accepted ticks, watch for a hang
    always @(posedge i_clk) begin : scoreboard
        t_led_pair want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (led_levels_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual status=%0d error=%0d",
                         $time, o_status_led_on, o_error_led_on);
                failures++;
            end else begin
                want = led_levels_q.pop_front();
                if (o_status_led_on !== want.status_on) begin
                    $display("%0t: status LED expected %0d actual %0d",
                             $time, want.status_on, o_status_led_on);
                    failures++;
                end
                if (o_error_led_on !== want.error_on) begin
                    $display("%0t: error LED expected %0d actual %0d",
                             $time, want.error_on, o_error_led_on);
                    failures++;
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            want = next_led_levels(i_elapsed_ms, i_motor_status);
            if (tick_typed) want = tick_leds;
            led_levels_q.push_back(want);
        end
        word_taken <= i_rst_n && i_in_valid && o_in_ready;

        if (i_in_valid && o_in_ready || o_out_valid && i_out_ready || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: stall on an 8-bit ready pattern, reloaded per style
    always @(negedge i_clk) begin
        if (stall_slot == 3'd0) begin
            case (stall_style)
                2'd0:    ready_pattern = '1;
                2'd1:    ready_pattern = 8'($urandom);
                default: ready_pattern = 8'($urandom & $urandom);
            endcase
        end
        i_out_ready <= ready_pattern[stall_slot];
        stall_slot  <= stall_slot + 3'd1;
    end

    // call at a falling edge; returns at the falling edge after the word is taken
    task automatic send_tick(input logic [slhb_pkg::MsW-1:0] ms,
                             input logic [slhb_pkg::StatusW-1:0] code,
                             input logic typed, input t_led_pair leds);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end else begin
            burst_left--;
        end
        i_in_valid     <= 1'b1;
        i_elapsed_ms   <= ms;
        i_motor_status <= code;
        tick_typed     <= typed;
        tick_leds      <= leds;
        do @(negedge i_clk); while (!word_taken);
    endtask

    // drain, then load all four thresholds
    task automatic write_thresholds(input logic [slhb_pkg::MsW-1:0] s,
                                    input logic [slhb_pkg::MsW-1:0] l,
                                    input logic [slhb_pkg::MsW-1:0] st,
                                    input logic [slhb_pkg::MsW-1:0] g);
        i_in_valid <= 1'b0;
        while (led_levels_q.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= slhb_pkg::CFG_HB_SHORT;   i_cfg_data <= s;  @(negedge i_clk);
        i_cfg_index <= slhb_pkg::CFG_HB_LONG;    i_cfg_data <= l;  @(negedge i_clk);
        i_cfg_index <= slhb_pkg::CFG_BLINK_STEP; i_cfg_data <= st; @(negedge i_clk);
        i_cfg_index <= slhb_pkg::CFG_BLINK_GAP;  i_cfg_data <= g;  @(negedge i_clk);
        i_cfg_we <= 1'b0;
        thr_short = s;
        thr_long  = l;
        thr_step  = st;
        thr_gap   = g;
        @(negedge i_clk);
    endtask

    // bias elapsed time toward the threshold boundaries
    function automatic logic [slhb_pkg::MsW-1:0] pick_ms(input int unsigned scale);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return thr_short;
            3:       return thr_short + 16'd1;
            4:       return thr_step;
            5:       return thr_step + 16'd1;
            6:       return slhb_pkg::MsW'($urandom_range(0, 65535));
            default: return slhb_pkg::MsW'($urandom_range(0, scale));
        endcase
    endfunction

    function automatic logic [slhb_pkg::StatusW-1:0] pick_code();
        if ($urandom_range(0, 19) < 3)
            return slhb_pkg::StatusW'($urandom_range(6, 7));
        return slhb_pkg::StatusW'($urandom_range(0, 5));
    endfunction

    // hold each status for a run of ticks, as a motor controller would
    task automatic run_ticks(input int count, input int unsigned scale);
        logic [slhb_pkg::StatusW-1:0] code;
        int run;
        int sent;
        sent = 0;
        while (sent < count) begin
            code = pick_code();
            run  = $urandom_range(1, 30);
            for (int k = 0; k < run && sent < count; k++) begin
                send_tick(pick_ms(scale), code, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        logic [slhb_pkg::StatusW-1:0] code;
        int extra;
        int run;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < ScriptLen; r++)
            send_tick(script[r].ms, script[r].code, script[r].typed, script[r].leds);

        for (int p = 0; p < 7; p++) begin
            // full rate, no stalls, in the sixth pass
            stall_style <= (p == 5) ? 2'd0 : 2'(p % 3);
            gaps_on = (p != 5);
            case (p)
                0: begin
                    // zero thresholds: any nonzero step moves a phase
                    write_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
                    run_ticks(PhaseTicks, 3);
                end
                1: begin
                    write_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                    run_ticks(PhaseTicks, 65535);
                end
                2: begin
                    write_thresholds(slhb_pkg::MsW'($urandom_range(0, 400)),
                                     slhb_pkg::MsW'($urandom_range(0, 400)),
                                     slhb_pkg::MsW'($urandom_range(0, 400)),
                                     slhb_pkg::MsW'($urandom_range(0, 400)));
                    run_ticks(PhaseTicks, 250);
                end
                3: begin
                    write_thresholds(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
                    run_ticks(PhaseTicks, 200);
                end
                4: begin
                    write_thresholds(slhb_pkg::MsW'($urandom), slhb_pkg::MsW'($urandom),
                                     slhb_pkg::MsW'($urandom), slhb_pkg::MsW'($urandom));
                    run_ticks(PhaseTicks, 40000);
                end
                5: begin
                    write_thresholds(slhb_pkg::MsW'($urandom_range(1, 50)),
                                     slhb_pkg::MsW'($urandom_range(1, 50)),
                                     slhb_pkg::MsW'($urandom_range(1, 50)),
                                     slhb_pkg::MsW'($urandom_range(1, 50)));
                    run_ticks(PhaseTicks, 60);
                end
                default: begin
                    write_thresholds(slhb_pkg::HB_SHORT_RST, slhb_pkg::HB_LONG_RST,
                                     slhb_pkg::BLINK_STEP_RST, slhb_pkg::BLINK_GAP_RST);
                    run_ticks(PhaseTicks, 600);
                end
            endcase
        end

        // large elapsed steps back to back, with an occasional zero step
        stall_style <= 2'd0;
        gaps_on = 1'b0;
        write_thresholds(slhb_pkg::MsW'($urandom), slhb_pkg::MsW'($urandom),
                         slhb_pkg::MsW'($urandom), slhb_pkg::MsW'($urandom));
        extra = 0;
        while (extra < PhaseTicks) begin
            code = pick_code();
            run  = $urandom_range(1, 30);
            for (int k = 0; k < run && extra < PhaseTicks; k++) begin
                send_tick(($urandom_range(0, 15) == 0) ? slhb_pkg::MsW'(0)
                          : slhb_pkg::MsW'($urandom_range(60000, 65535)), code, 1'b0, '0);
                extra++;
            end
        end

        i_in_valid  <= 1'b0;
        stall_style <= 2'd1;
        while (led_levels_q.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
